/* sv/bdhtd_pkg.sv */
// Package for the button debounce, hold and tap detector.
// Holds the register map, field widths and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package bdhtd_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_W  = 16;
  localparam int HOLD_W = 16;
  localparam int TAPS_W = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_LONG_PRESS  = 2'd1,
    REG_SHORT_PRESS = 2'd2,
    REG_TAP_TIMEOUT = 2'd3
  } reg_idx_e;

  // Register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] SHORT_PRESS_RST = 16'd300;
  localparam logic [CFG_W-1:0] TAP_TIMEOUT_RST = 16'd400;

endpackage

/* sv/button_debounce_hold_tap_detector.sv */
// Button debouncer with press/release edges, long-hold flag and tap counter.
// Top level; uses bdhtd_pkg for the register map and field widths.
// Each input item is one tick: a raw sample and a clear-taps flag.
`timescale 1ns / 1ps

// One item is one millisecond tick and yields exactly one result item. An
// item passes an input register, then combinational compare-and-increment
// logic that updates the debounce, hold and tap counters and fills the result
// register, so the block takes one item per clock while the output is not
// stalled, and each result item is presented from the result register. The
// input register and the result register both hold while the output is
// stalled.
// Counters are COUNT_WIDTH bits, the tap counter TAP_COUNT_WIDTH bits, and
// all saturate; hold_ticks_o is clamped to 16 bits and taps_done_o to 4 bits.
// Registers sit on a 4-bit APB address at byte offsets 0, 4, 8 and 12 and
// should be written only while the block is idle.
module button_debounce_hold_tap_detector #(
  parameter int COUNT_WIDTH     = 16,
  parameter int TAP_COUNT_WIDTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Tick items.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              raw_pressed_i,
  input  logic                              clear_taps_i,
  // Result items.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              pressed_o,
  output logic                              just_pressed_o,
  output logic                              just_released_o,
  output logic                              held_long_o,
  output logic [bdhtd_pkg::HOLD_W-1:0]      hold_ticks_o,
  output logic [bdhtd_pkg::TAPS_W-1:0]      taps_done_o,
  // Configuration.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdhtd_pkg::ADDR_W-1:0]      paddr,
  input  logic [bdhtd_pkg::DATA_W-1:0]      pwdata,
  output logic [bdhtd_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int CmpW = (COUNT_WIDTH > bdhtd_pkg::CFG_W) ? COUNT_WIDTH : bdhtd_pkg::CFG_W;
  localparam int TapCmpW =
      (TAP_COUNT_WIDTH > bdhtd_pkg::TAPS_W) ? TAP_COUNT_WIDTH : bdhtd_pkg::TAPS_W;
  localparam logic [COUNT_WIDTH-1:0]     CntMax = {COUNT_WIDTH{1'b1}};
  localparam logic [TAP_COUNT_WIDTH-1:0] TapMax = {TAP_COUNT_WIDTH{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bdhtd_pkg::CFG_W-1:0] debounce_q, long_press_q, short_press_q, tap_timeout_q;
  bdhtd_pkg::reg_idx_e         reg_idx;
  logic                        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = bdhtd_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= bdhtd_pkg::DEBOUNCE_RST;
      long_press_q  <= bdhtd_pkg::LONG_PRESS_RST;
      short_press_q <= bdhtd_pkg::SHORT_PRESS_RST;
      tap_timeout_q <= bdhtd_pkg::TAP_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        bdhtd_pkg::REG_DEBOUNCE:    debounce_q    <= pwdata[bdhtd_pkg::CFG_W-1:0];
        bdhtd_pkg::REG_LONG_PRESS:  long_press_q  <= pwdata[bdhtd_pkg::CFG_W-1:0];
        bdhtd_pkg::REG_SHORT_PRESS: short_press_q <= pwdata[bdhtd_pkg::CFG_W-1:0];
        bdhtd_pkg::REG_TAP_TIMEOUT: tap_timeout_q <= pwdata[bdhtd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      bdhtd_pkg::REG_DEBOUNCE:    prdata = bdhtd_pkg::DATA_W'(debounce_q);
      bdhtd_pkg::REG_LONG_PRESS:  prdata = bdhtd_pkg::DATA_W'(long_press_q);
      bdhtd_pkg::REG_SHORT_PRESS: prdata = bdhtd_pkg::DATA_W'(short_press_q);
      bdhtd_pkg::REG_TAP_TIMEOUT: prdata = bdhtd_pkg::DATA_W'(tap_timeout_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic s1_valid_q, raw_q, clr_q;
  logic s1_fire, out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      raw_q <= raw_pressed_i;
      clr_q <= clear_taps_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick state and next-state logic
  // ---------------------------------------------------------------------------
  logic                       stable_q, stable_d;
  logic [COUNT_WIDTH-1:0]     mismatch_q, mismatch_d, mismatch_inc;
  logic [COUNT_WIDTH-1:0]     press_q, press_d, press_inc;
  logic [COUNT_WIDTH-1:0]     since_q, since_d;
  logic [TAP_COUNT_WIDTH-1:0] taps_q, taps_d;
  logic                       rise, fall, held_long;
  logic [CmpW-1:0]            press_ext;
  logic [TapCmpW-1:0]         taps_ext;
  logic [bdhtd_pkg::HOLD_W-1:0] hold_val;
  logic [bdhtd_pkg::TAPS_W-1:0] taps_val;

  assign mismatch_inc = (mismatch_q == CntMax) ? CntMax : mismatch_q + 1'b1;
  assign press_inc    = (press_q == CntMax) ? CntMax : press_q + 1'b1;

  always_comb begin
    // Debounce: a differing level is taken once it has differed for more
    // than the debounce time.
    stable_d   = stable_q;
    mismatch_d = '0;
    if (raw_q != stable_q) begin
      if (CmpW'(mismatch_inc) > CmpW'(debounce_q)) begin
        stable_d = raw_q;
      end else begin
        mismatch_d = mismatch_inc;
      end
    end

    rise = stable_d && !stable_q;
    fall = !stable_d && stable_q;

    // The tap timer runs every tick; a short press restarts it on release.
    since_d = (since_q == CntMax) ? CntMax : since_q + 1'b1;
    taps_d  = taps_q;
    if (fall && (CmpW'(press_inc) < CmpW'(short_press_q))) begin
      taps_d  = (taps_q == TapMax) ? TapMax : taps_q + 1'b1;
      since_d = '0;
    end

    // The press edge tick counts as zero held ticks.
    press_d = (stable_d && !rise) ? press_inc : '0;

    if (clr_q) begin
      taps_d  = '0;
      since_d = CntMax;
    end

    held_long = stable_d && !rise && (CmpW'(press_d) >= CmpW'(long_press_q));

    press_ext = CmpW'(press_d);
    if (!stable_d) begin
      hold_val = '0;
    end else if (press_ext > CmpW'({bdhtd_pkg::HOLD_W{1'b1}})) begin
      hold_val = '1;
    end else begin
      hold_val = press_ext[bdhtd_pkg::HOLD_W-1:0];
    end

    taps_ext = TapCmpW'(taps_d);
    if ((taps_d == '0) || stable_d ||
        !(CmpW'(since_d) > CmpW'(tap_timeout_q))) begin
      taps_val = '0;
    end else if (taps_ext > TapCmpW'({bdhtd_pkg::TAPS_W{1'b1}})) begin
      taps_val = '1;
    end else begin
      taps_val = taps_ext[bdhtd_pkg::TAPS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b0;
      mismatch_q <= '0;
      press_q    <= '0;
      since_q    <= CntMax;
      taps_q     <= '0;
    end else if (s1_fire) begin
      stable_q   <= stable_d;
      mismatch_q <= mismatch_d;
      press_q    <= press_d;
      since_q    <= since_d;
      taps_q     <= taps_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pressed_o       <= stable_d;
      just_pressed_o  <= rise;
      just_released_o <= fall;
      held_long_o     <= held_long;
      hold_ticks_o    <= hold_val;
      taps_done_o     <= taps_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_edges_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(just_pressed_o && just_released_o))
    else $error("press and release edges reported on the same item");

  a_edge_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && just_pressed_o) |-> (pressed_o && hold_ticks_o == '0))
    else $error("press edge without pressed level or with nonzero hold count");

  a_held_long_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && held_long_o) |-> (pressed_o && !just_pressed_o))
    else $error("long hold flagged while released or on the press edge");

  a_taps_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && taps_done_o != '0) |-> (!pressed_o && hold_ticks_o == '0))
    else $error("tap count reported while the button is pressed");

  a_state_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_o && pressed_o == stable_q))
    else $error("result level differs from the debounced state");

endmodule
